// ===== sv/itoa_pkg.sv =====
// shared constants, types and state codes for the signed decimal text converter
package itoa_pkg;

  // width of the value port and the part of it that is converted
  localparam int IN_BITS    = 64;
  localparam int VALUE_BITS = 64;

  // decimal digits held by the bcd register, enough for 2^64
  localparam int BCD_DIGITS = 20;
  localparam int BCD_BITS   = 4 * BCD_DIGITS;

  localparam int BIT_CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int DIGIT_CNT_W = $clog2(BCD_DIGITS);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_EMIT
  } itoa_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic convert;
    logic sign;
    logic digit;
  } itoa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic conv_last;
    logic neg;
    logic digit_last;
  } itoa_sts_t;

endpackage

// ===== sv/itoa_ctrl.sv =====
// sequencing state machine for the signed decimal text converter
module itoa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_cmd_t cmd,
  output logic                busy
);
  import itoa_pkg::*;

  itoa_state_t state;
  itoa_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (sts.conv_last) begin
          state_next = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.digit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONVERT: begin
        cmd.convert = 1'b1;
      end
      ST_SIGN: begin
        cmd.sign = 1'b1;
      end
      ST_EMIT: begin
        cmd.digit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/itoa_dp.sv =====
// magnitude, shift-add-3 bcd conversion and character output registers
module itoa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itoa_pkg::IN_BITS-1:0] value,
  input  itoa_pkg::itoa_cmd_t          cmd,
  output itoa_pkg::itoa_sts_t          sts,
  output logic [7:0]                   text_char,
  output logic                         last_char,
  output logic                         strobe
);
  import itoa_pkg::*;

  logic [VALUE_BITS-1:0]  bin;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic                   neg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIGIT_CNT_W-1:0] digit_cnt;
  logic                   seen;
  logic [VALUE_BITS-1:0]  x;
  logic [VALUE_BITS-1:0]  mag;
  logic [3:0]             top;
  logic                   show;

  // magnitude of the low bits read as two's complement
  assign x   = value[VALUE_BITS-1:0];
  assign mag = x[VALUE_BITS-1] ? (~x + VALUE_BITS'(1)) : x;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? (bcd[4*d +: 4] + 4'd3)
                                                  : bcd[4*d +: 4];
    end
  end

  // leading zeros are dropped, the final digit always shows
  assign top  = bcd[BCD_BITS-1 -: 4];
  assign show = (top != 4'd0) || seen || (digit_cnt == '0);

  assign sts.conv_last  = (bit_cnt == BIT_CNT_W'(1));
  assign sts.neg        = neg;
  assign sts.digit_last = (digit_cnt == '0);

  // conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin       <= mag;
      neg       <= x[VALUE_BITS-1];
      bcd       <= '0;
      bit_cnt   <= BIT_CNT_W'(VALUE_BITS);
      digit_cnt <= DIGIT_CNT_W'(BCD_DIGITS - 1);
      seen      <= 1'b0;
    end else if (cmd.convert) begin
      bcd     <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_BITS-1]};
      bin     <= {bin[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end else if (cmd.digit) begin
      bcd       <= {bcd[BCD_BITS-5:0], 4'd0};
      digit_cnt <= digit_cnt - DIGIT_CNT_W'(1);
      seen      <= seen | show;
    end
  end

  // output beat strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.sign || (cmd.digit && show);
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.sign) begin
      text_char <= ASCII_MINUS;
      last_char <= 1'b0;
    end else if (cmd.digit) begin
      text_char <= ASCII_ZERO + {4'd0, top};
      last_char <= (digit_cnt == '0);
    end
  end

  // a beat always carries a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (text_char == ASCII_MINUS) ||
               ((text_char >= ASCII_ZERO) && (text_char <= ASCII_NINE)))
    else $error("character out of range");

  // the sign never ends a run
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (text_char == ASCII_MINUS) |-> !last_char)
    else $error("minus sign flagged as last");

  // a sign is only issued for a negative value
  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    cmd.sign |-> neg)
    else $error("sign issued for non-negative value");

  // the end of a run is followed by a quiet cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("beat right after last character");

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// top level of the signed integer to decimal ascii text converter
// A number is taken when start is high and busy is low. Its text leaves one character per
// beat, most significant first, each beat marked by strobe for one cycle, with a leading
// minus for negative values and last_char on the final digit; the receiver cannot stall.
// After acceptance the magnitude goes through the shift-add-3 bcd unit one bit a cycle,
// a negative number then has its minus sign issued, and a scan of all 20 bcd digits
// follows one digit a cycle, leading zeros leaving no beat. A new number is taken only
// after the last digit of the previous one has been scanned.
module signed_int_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itoa_pkg::IN_BITS-1:0] value,
  output logic                         busy,
  output logic [7:0]                   text_char,
  output logic                         last_char,
  output logic                         strobe
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // sequencer
  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // conversion datapath
  itoa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .text_char (text_char),
    .last_char (last_char),
    .strobe    (strobe)
  );

endmodule
